// ===== rtl/core/ntc_thermistor_to_celsius_assert.svh =====
// Assertion macros shared by the checker of the thermistor converter.
`ifndef NTC_THERMISTOR_TO_CELSIUS_ASSERT_SVH
`define NTC_THERMISTOR_TO_CELSIUS_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define NTC_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ntc assertion failed");

// Condition c must hold in the cycle after a.
`define NTC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ntc assertion failed");

`endif

// ===== rtl/core/ntc_pkg.sv =====
// ---------------------------------------------------------------------------
// ntc_pkg
// Shared widths, register indexes, constants and the divider request type.
// ---------------------------------------------------------------------------
package ntc_pkg;

  localparam int DVD_W = 52;
  localparam int DVS_W = 32;
  localparam int CNT_W = 6;

  localparam logic [2:0] REG_BITS    = 3'd0;
  localparam logic [2:0] REG_SERIES  = 3'd1;
  localparam logic [2:0] REG_NOMINAL = 3'd2;
  localparam logic [2:0] REG_TNOM    = 3'd3;
  localparam logic [2:0] REG_BETA    = 3'd4;

  localparam logic [15:0] INVALID_TEMP = 16'h8000;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/core/ntc_div.sv =====
// ---------------------------------------------------------------------------
// ntc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ntc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  ntc_pkg::div_req_t        req,
  output logic                     done,
  output logic [ntc_pkg::DVD_W-1:0] quotient
);
  import ntc_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic             take;

  assign trial    = {rem, quo[DVD_W-1]};
  assign take     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        quo <= {quo[DVD_W-2:0], take};
        rem <= take ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ntc_thermistor_to_celsius.sv =====
// ---------------------------------------------------------------------------
// ntc_thermistor_to_celsius
// Converts a thermistor divider sample to tenths of a degree Celsius.
// ---------------------------------------------------------------------------
// A result takes six passes through the shared 52-step divider plus the log range
// reduction, which halves or doubles the ratio as needed. A zero or full-scale
// sample faults from the check state without using the divider.
// Throughput: one sample at a time; a new request is taken once the previous
// result has moved to the output register. Synchronous reset restores the
// register defaults and empties the pipeline.
module ntc_thermistor_to_celsius (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] temp_tenths,
  output logic        fault
);
  import ntc_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CHECK  = 5'd1;
  localparam logic [4:0] ST_RES    = 5'd2;
  localparam logic [4:0] ST_RESDIV = 5'd3;
  localparam logic [4:0] ST_RATDIV = 5'd4;
  localparam logic [4:0] ST_NORM   = 5'd5;
  localparam logic [4:0] ST_UDIV   = 5'd6;
  localparam logic [4:0] ST_U2     = 5'd7;
  localparam logic [4:0] ST_U4     = 5'd8;
  localparam logic [4:0] ST_U6     = 5'd9;
  localparam logic [4:0] ST_T1     = 5'd10;
  localparam logic [4:0] ST_T2     = 5'd11;
  localparam logic [4:0] ST_T3     = 5'd12;
  localparam logic [4:0] ST_SUM    = 5'd13;
  localparam logic [4:0] ST_LN     = 5'd14;
  localparam logic [4:0] ST_TNOM   = 5'd15;
  localparam logic [4:0] ST_INOM   = 5'd16;
  localparam logic [4:0] ST_DELTA  = 5'd17;
  localparam logic [4:0] ST_TK     = 5'd18;
  localparam logic [4:0] ST_C10    = 5'd19;
  localparam logic [4:0] ST_FAULT  = 5'd20;
  localparam logic [4:0] ST_DONE   = 5'd21;

  localparam logic [DVD_W-1:0] ONE_Q32 = DVD_W'(64'h1_0000_0000);

  logic [4:0]  state;
  logic [4:0]  bits_r;
  logic [19:0] series_r;
  logic [19:0] nominal_r;
  logic signed [11:0] tnom_r;
  logic [16:0] beta_r;

  logic [15:0] raw_r;
  logic [31:0] full_r;
  logic [31:0] xr;
  logic signed [5:0] n_r;
  logic        neg_r;
  logic signed [16:0] u_r;
  logic [12:0] u2_r;
  logic [9:0]  u4_r;
  logic [6:0]  u6_r;
  logic [16:0] acc_r;
  logic signed [23:0] lnr_r;
  logic [9:0]  inv_nom_r;
  logic [15:0] res_temp;
  logic        res_fault;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;

  div_req_t         div_req;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic [31:0]        num_abs;
  logic signed [16:0] u_val;
  logic [16:0]        acc_new;
  logic signed [31:0] tnom_v;
  logic [23:0]        lnr_abs;
  logic signed [24:0] delta;
  logic signed [24:0] inv_t;
  logic signed [20:0] c10;
  logic               q_big;

  ntc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // The one multiplier: operands are registered, every consumer registers the product.
  assign prod = mul_a * mul_b;

  assign num_abs = (xr < 32'd65536) ? (32'd65536 - xr) : (xr - 32'd65536);
  assign u_val   = neg_r ? -$signed(div_q[16:0]) : $signed(div_q[16:0]);
  assign acc_new = acc_r + 17'(prod[19:16]);
  assign tnom_v  = $signed(prod[31:0]) + 32'sd17904742;
  assign lnr_abs = lnr_r[23] ? 24'(-lnr_r) : lnr_r;
  assign delta   = neg_r ? -$signed({1'b0, div_q[23:0]}) : $signed({1'b0, div_q[23:0]});
  assign inv_t   = $signed({15'd0, inv_nom_r}) + delta;
  assign c10     = $signed({2'b00, prod[34:16]}) - 21'sd2731;
  assign q_big   = div_q[DVD_W-1:31] != '0;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
      bits_r        <= 5'd12;
      series_r      <= 20'd10000;
      nominal_r     <= 20'd10000;
      tnom_r        <= 12'sd250;
      beta_r        <= 17'd3950;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BITS:    bits_r    <= cfg_data[4:0];
          REG_SERIES:  series_r  <= cfg_data;
          REG_NOMINAL: nominal_r <= cfg_data;
          REG_TNOM:    tnom_r    <= $signed(cfg_data[11:0]);
          REG_BETA:    beta_r    <= cfg_data[16:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            raw_r  <= raw_sample;
            full_r <= 32'((33'd1 << bits_r) - 33'd1);
            state  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (raw_r == 16'd0 || {16'd0, raw_r} >= full_r) begin
            state <= ST_FAULT;
          end else begin
            mul_a <= {14'd0, series_r};
            mul_b <= {2'b00, raw_r};
            state <= ST_RES;
          end
        end
        ST_RES: begin
          div_req.start    <= 1'b1;
          div_req.dividend <= {prod[35:0], 16'd0};
          div_req.divisor  <= full_r - {16'd0, raw_r};
          state            <= ST_RESDIV;
        end
        ST_RESDIV: begin
          if (div_done) begin
            if (div_q == '0 || q_big || nominal_r == 20'd0) begin
              state <= ST_FAULT;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= {5'd0, div_q[30:0], 16'd0};
              div_req.divisor  <= {12'd0, nominal_r};
              state            <= ST_RATDIV;
            end
          end
        end
        ST_RATDIV: begin
          if (div_done) begin
            if (div_q == '0 || q_big) begin
              state <= ST_FAULT;
            end else begin
              xr    <= div_q[31:0];
              n_r   <= '0;
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          // Halve or double until the ratio sits in [0.5, 2).
          if (xr >= 32'd131072) begin
            xr  <= xr >> 1;
            n_r <= n_r + 6'sd1;
          end else if (xr < 32'd32768) begin
            xr  <= xr << 1;
            n_r <= n_r - 6'sd1;
          end else begin
            neg_r            <= xr < 32'd65536;
            div_req.start    <= 1'b1;
            div_req.dividend <= {19'd0, num_abs[16:0], 16'd0};
            div_req.divisor  <= xr + 32'd65536;
            state            <= ST_UDIV;
          end
        end
        ST_UDIV: begin
          if (div_done) begin
            u_r   <= u_val;
            mul_a <= {{17{u_val[16]}}, u_val};
            mul_b <= {u_val[16], u_val};
            state <= ST_U2;
          end
        end
        ST_U2: begin
          u2_r  <= prod[28:16];
          mul_a <= {21'd0, prod[28:16]};
          mul_b <= {5'd0, prod[28:16]};
          state <= ST_U4;
        end
        ST_U4: begin
          u4_r  <= prod[25:16];
          mul_a <= {24'd0, prod[25:16]};
          mul_b <= {5'd0, u2_r};
          state <= ST_U6;
        end
        ST_U6: begin
          u6_r  <= prod[22:16];
          mul_a <= {21'd0, u2_r};
          mul_b <= 18'sd21845;
          state <= ST_T1;
        end
        ST_T1: begin
          acc_r <= 17'd65536 + 17'(prod[27:16]);
          mul_a <= {24'd0, u4_r};
          mul_b <= 18'sd13107;
          state <= ST_T2;
        end
        ST_T2: begin
          acc_r <= acc_r + 17'(prod[23:16]);
          mul_a <= {27'd0, u6_r};
          mul_b <= 18'sd9362;
          state <= ST_T3;
        end
        ST_T3: begin
          mul_a <= {{17{u_r[16]}}, u_r};
          mul_b <= {1'b0, acc_new};
          state <= ST_SUM;
        end
        ST_SUM: begin
          // Taking bits above 16 of the two's complement product is a floor shift.
          lnr_r <= {{7{prod[31]}}, prod[31:16], 1'b0};
          mul_a <= {{28{n_r[5]}}, n_r};
          mul_b <= 18'sd45426;
          state <= ST_LN;
        end
        ST_LN: begin
          lnr_r <= lnr_r + prod[23:0];
          mul_a <= {{22{tnom_r[11]}}, tnom_r};
          mul_b <= 18'sd6554;
          state <= ST_TNOM;
        end
        ST_TNOM: begin
          if (tnom_v <= 0 || beta_r == 17'd0) begin
            state <= ST_FAULT;
          end else begin
            neg_r            <= lnr_r[23];
            div_req.start    <= 1'b1;
            div_req.dividend <= ONE_Q32;
            div_req.divisor  <= tnom_v;
            state            <= ST_INOM;
          end
        end
        ST_INOM: begin
          if (div_done) begin
            inv_nom_r        <= div_q[9:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= {28'd0, lnr_abs};
            div_req.divisor  <= {15'd0, beta_r};
            state            <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          if (div_done) begin
            if (inv_t[24] || inv_t == '0) begin
              state <= ST_FAULT;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= ONE_Q32;
              div_req.divisor  <= {8'd0, inv_t[23:0]};
              state            <= ST_TK;
            end
          end
        end
        ST_TK: begin
          if (div_done) begin
            if (q_big) begin
              state <= ST_FAULT;
            end else begin
              mul_a <= {3'd0, div_q[30:0]};
              mul_b <= 18'sd10;
              state <= ST_C10;
            end
          end
        end
        ST_C10: begin
          if (c10 > 21'sd32767) begin
            state <= ST_FAULT;
          end else begin
            res_temp  <= c10[15:0];
            res_fault <= 1'b0;
            state     <= ST_DONE;
          end
        end
        ST_FAULT: begin
          res_temp  <= INVALID_TEMP;
          res_fault <= 1'b1;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            temp_tenths <= res_temp;
            fault       <= res_fault;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ntc_checker.sv =====
// ---------------------------------------------------------------------------
// ntc_checker
// Port-level checks of the thermistor converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "ntc_thermistor_to_celsius_assert.svh"

module ntc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [15:0] temp_tenths,
  input logic        fault
);

  // A faulted result always carries the invalid code.
  `NTC_ASSERT_IMPLY(a_fault_code, clk, rst, out_valid && fault, temp_tenths == 16'sh8000)

  // A good result can never fall on the invalid code.
  `NTC_ASSERT_IMPLY(a_good_code, clk, rst, out_valid && !fault, temp_tenths != 16'sh8000)

  // The block works on one request at a time.
  `NTC_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)

  `NTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(temp_tenths) && $stable(fault))

endmodule

bind ntc_thermistor_to_celsius ntc_checker u_ntc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .temp_tenths (temp_tenths),
  .fault       (fault)
);
